// ===== hw/rtl/dhsv_pkg.sv =====
// Package for the dual HSV range pixel mask: widths, register codes, types.
`default_nettype none
package dhsv_pkg;

    localparam int PIX_W      = 8;
    localparam int HUE_W      = 9;
    localparam int HUE_CFG_W  = 2 * HUE_W;
    localparam int SV_CFG_W   = 2 * PIX_W;
    localparam int CFG_DATA_W = HUE_CFG_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = 21;

    localparam int SAT_SCALE        = 255;
    localparam int HUE_FULL         = 360;
    localparam int MAX_FRAME_PIXELS = 1048576;
    localparam int CNT_FIELD_MAX    = (1 << CNT_W) - 1;
    localparam int CNT_LIMIT_I      = (MAX_FRAME_PIXELS < CNT_FIELD_MAX) ?
                                      MAX_FRAME_PIXELS : CNT_FIELD_MAX;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CNT_LIMIT_I);

    // hue numerator < 360 * 255, bound products up to 511 * 255
    localparam int HNUM_W  = HUE_W + PIX_W;
    localparam int SPROD_W = 2 * PIX_W;

    localparam logic [HUE_CFG_W-1:0] HUE_RST = HUE_CFG_W'(184320);
    localparam logic [SV_CFG_W-1:0]  SV_RST  = SV_CFG_W'(65280);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE0 = 3'd0,
        CFG_SAT0 = 3'd1,
        CFG_VAL0 = 3'd2,
        CFG_HUE1 = 3'd3,
        CFG_SAT1 = 3'd4,
        CFG_VAL1 = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [HNUM_W-1:0]  hnum;
        logic [PIX_W-1:0]   hden;
        logic [SPROD_W-1:0] snum;
        logic [PIX_W-1:0]   sden;
        logic [PIX_W-1:0]   vmax;
    } t_hsv_terms;

    typedef struct packed {
        logic [HUE_CFG_W-1:0] hue;
        logic [SV_CFG_W-1:0]  sat;
        logic [SV_CFG_W-1:0]  val;
    } t_range_cfg;

endpackage
`default_nettype wire

// ===== hw/rtl/dhsv_pix_if.sv =====
// Handshake interfaces for the pixel input and mask result channels.
`default_nettype none
interface dhsv_pix_if import dhsv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             frame_end;

    modport source (output valid, blue, green, red, frame_end, input ready);
    modport sink   (input valid, blue, green, red, frame_end, output ready);
endinterface

interface dhsv_res_if import dhsv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_red;
    logic             in_first_range;
    logic             in_second_range;
    logic [CNT_W-1:0] match_count;
    logic             count_valid;

    modport source (output valid, out_blue, out_green, out_red, in_first_range,
                    in_second_range, match_count, count_valid, input ready);
    modport sink   (input valid, out_blue, out_green, out_red, in_first_range,
                    in_second_range, match_count, count_valid, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dhsv_terms.sv =====
// Exact HSV numerators and denominators of one BGR pixel.
`default_nettype none
module dhsv_terms import dhsv_pkg::*; (
    input  wire logic [PIX_W-1:0] i_blue,
    input  wire logic [PIX_W-1:0] i_green,
    input  wire logic [PIX_W-1:0] i_red,
    output t_hsv_terms            o_terms
);
    logic [PIX_W-1:0]  mx, mn, d, p, q, mag;
    logic [HNUM_W-1:0] base, m60;
    logic              neg;

    always_comb begin
        mx = i_blue;
        mn = i_blue;
        if (i_green > mx) mx = i_green;
        if (i_red > mx)   mx = i_red;
        if (i_green < mn) mn = i_green;
        if (i_red < mn)   mn = i_red;
        d = mx - mn;

        // hue = base +/- 60 * |p - q|; only the red sector can wrap
        if (mx == i_red) begin
            p    = i_green;
            q    = i_blue;
            base = (i_green >= i_blue) ? '0 : HNUM_W'(d) * HNUM_W'(HUE_FULL);
        end else if (mx == i_green) begin
            p    = i_blue;
            q    = i_red;
            base = HNUM_W'(d) * HNUM_W'(120);
        end else begin
            p    = i_red;
            q    = i_green;
            base = HNUM_W'(d) * HNUM_W'(240);
        end
        neg = (p < q);
        mag = neg ? (q - p) : (p - q);
        m60 = HNUM_W'(mag) * HNUM_W'(60);

        o_terms.hnum = neg ? (base - m60) : (base + m60);
        o_terms.hden = (d == '0) ? PIX_W'(1) : d;
        o_terms.snum = SPROD_W'(d) * SPROD_W'(SAT_SCALE);
        o_terms.sden = (mx == '0) ? PIX_W'(1) : mx;
        o_terms.vmax = mx;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/dhsv_range_chk.sv =====
// Inclusive cross-multiplied test of HSV terms against one configured range.
`default_nettype none
module dhsv_range_chk import dhsv_pkg::*; (
    input  wire t_hsv_terms i_terms,
    input  wire t_range_cfg i_cfg,
    output logic            o_match
);
    logic [HNUM_W-1:0]  h_lo, h_hi;
    logic [SPROD_W-1:0] s_lo, s_hi;
    logic               h_ok, s_ok, v_ok;

    always_comb begin
        h_lo = HNUM_W'(i_cfg.hue[HUE_W-1:0]) * HNUM_W'(i_terms.hden);
        h_hi = HNUM_W'(i_cfg.hue[HUE_CFG_W-1:HUE_W]) * HNUM_W'(i_terms.hden);
        s_lo = SPROD_W'(i_cfg.sat[PIX_W-1:0]) * SPROD_W'(i_terms.sden);
        s_hi = SPROD_W'(i_cfg.sat[SV_CFG_W-1:PIX_W]) * SPROD_W'(i_terms.sden);

        h_ok = (h_lo <= i_terms.hnum) && (i_terms.hnum <= h_hi);
        s_ok = (s_lo <= i_terms.snum) && (i_terms.snum <= s_hi);
        // value scale equals the channel scale, so the test is direct
        v_ok = (i_cfg.val[PIX_W-1:0] <= i_terms.vmax) &&
               (i_terms.vmax <= i_cfg.val[SV_CFG_W-1:PIX_W]);
        o_match = h_ok && s_ok && v_ok;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/dual_hsv_range_pixel_mask_unit.sv =====
// Dual HSV range pixel mask: top level with pipeline, config and frame count.
// An accepted input transaction reaches its result valid through the input
// register, then the result register.
// Throughput: one pixel per clock; the two-stage pipeline stalls only when
// the result register is full and not taken.
// Reset (synchronous, active low) empties the pipeline, clears the frame count
// and loads the range registers with hue 0..360, sat 0..255, val 0..255.
`default_nettype none
module dual_hsv_range_pixel_mask_unit import dhsv_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    dhsv_pix_if.sink                   i_pix,
    dhsv_res_if.source                 o_res
);
    t_range_cfg       r_cfg [2];
    logic             r_in_vld, r_out_vld;
    logic [PIX_W-1:0] r_b, r_g, r_r;
    logic             r_last;
    logic [CNT_W-1:0] r_cnt;
    logic [PIX_W-1:0] r_ob, r_og, r_or;
    logic             r_m1, r_m2, r_ocv;
    logic [CNT_W-1:0] r_ocnt;

    t_hsv_terms       terms;
    logic             m1, m2, any, advance, in_ready;
    logic [CNT_W-1:0] n_cnt;

    assign advance   = !r_out_vld || o_res.ready;
    assign in_ready  = !r_in_vld || advance;
    assign i_pix.ready = in_ready;

    dhsv_terms u_terms (
        .i_blue  (r_b),
        .i_green (r_g),
        .i_red   (r_r),
        .o_terms (terms)
    );

    dhsv_range_chk u_chk0 (.i_terms(terms), .i_cfg(r_cfg[0]), .o_match(m1));
    dhsv_range_chk u_chk1 (.i_terms(terms), .i_cfg(r_cfg[1]), .o_match(m2));

    assign any   = m1 || m2;
    assign n_cnt = (any && (r_cnt < CNT_LIMIT)) ? (r_cnt + CNT_W'(1)) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_cfg[k].hue <= HUE_RST;
                r_cfg[k].sat <= SV_RST;
                r_cfg[k].val <= SV_RST;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HUE0: r_cfg[0].hue <= i_cfg_data;
                CFG_SAT0: r_cfg[0].sat <= i_cfg_data[SV_CFG_W-1:0];
                CFG_VAL0: r_cfg[0].val <= i_cfg_data[SV_CFG_W-1:0];
                CFG_HUE1: r_cfg[1].hue <= i_cfg_data;
                CFG_SAT1: r_cfg[1].sat <= i_cfg_data[SV_CFG_W-1:0];
                CFG_VAL1: r_cfg[1].val <= i_cfg_data[SV_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (in_ready) begin
                r_in_vld <= i_pix.valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
                if (r_in_vld) begin
                    r_cnt <= r_last ? '0 : n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_pix.valid) begin
            r_b    <= i_pix.blue;
            r_g    <= i_pix.green;
            r_r    <= i_pix.red;
            r_last <= i_pix.frame_end;
        end
        if (advance && r_in_vld) begin
            r_ob   <= any ? r_b : '0;
            r_og   <= any ? r_g : '0;
            r_or   <= any ? r_r : '0;
            r_m1   <= m1;
            r_m2   <= m2;
            r_ocnt <= n_cnt;
            r_ocv  <= r_last;
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.out_blue        = r_ob;
    assign o_res.out_green       = r_og;
    assign o_res.out_red         = r_or;
    assign o_res.in_first_range  = r_m1;
    assign o_res.in_second_range = r_m2;
    assign o_res.match_count     = r_ocnt;
    assign o_res.count_valid     = r_ocv;
endmodule
`default_nettype wire
